// ===== rtl/core/u2d_pkg.sv =====
// Shared types and constants for the UTF-8 to UCS-2 decoder core.
// No dependencies; used by u2d_step and utf8_to_ucs2_decoder_core.
package u2d_pkg;

   localparam logic [15:0] SPACE_CODE = 16'h0020;

   // Slot values for the sequence counter; LAST_* doubles as length - 1.
   localparam logic [1:0] POS_LEAD  = 2'd0;
   localparam logic [1:0] POS_CONT1 = 2'd1;
   localparam logic [1:0] LAST_ONE   = 2'd0;
   localparam logic [1:0] LAST_TWO   = 2'd1;
   localparam logic [1:0] LAST_THREE = 2'd2;
   localparam logic [1:0] LAST_FOUR  = 2'd3;

   // Partial-character state carried between beats.
   typedef struct packed {
      logic [1:0] pos;   // slot of the next byte, POS_LEAD = expecting a lead byte
      logic [1:0] last;  // slot of the final byte of the current sequence
   } seq_state_type;

   // Per-beat decision from the step logic.
   typedef struct packed {
      logic        emit;      // sequence completes on this byte
      logic [15:0] code;      // assembled code unit
      logic        wr_lead;   // capture byte as lead byte
      logic        wr_cont1; // capture byte as first continuation byte
   } step_out_type;

endpackage

// ===== rtl/core/u2d_step.sv =====
// Combinational per-byte decode: lead classification, state advance and
// code assembly. Depends on u2d_pkg.
module u2d_step (
   input  logic [7:0]             data_byte,
   input  logic                   start_of_text,
   input  u2d_pkg::seq_state_type state,
   input  logic [7:0]             lead_byte,
   input  logic [7:0]             cont1_byte,
   output u2d_pkg::seq_state_type state_next,
   output u2d_pkg::step_out_type  result
);

   logic [1:0] pos;

   always_comb begin
      pos        = start_of_text ? u2d_pkg::POS_LEAD : state.pos;
      state_next = state;
      state_next.pos = pos;
      result.emit     = 1'b0;
      result.code     = {8'h00, data_byte};
      result.wr_lead  = 1'b0;
      result.wr_cont1 = 1'b0;

      if (pos == u2d_pkg::POS_LEAD) begin
         result.wr_lead = 1'b1;
         if (!data_byte[7]) begin
            state_next.last = u2d_pkg::LAST_ONE;
            result.emit     = 1'b1;
         end else if (data_byte[7:3] == 5'b11110) begin
            state_next.last = u2d_pkg::LAST_FOUR;
            state_next.pos  = u2d_pkg::POS_CONT1;
         end else if (data_byte[7:4] == 4'b1110) begin
            state_next.last = u2d_pkg::LAST_THREE;
            state_next.pos  = u2d_pkg::POS_CONT1;
         end else if (data_byte[7:5] == 3'b110) begin
            state_next.last = u2d_pkg::LAST_TWO;
            state_next.pos  = u2d_pkg::POS_CONT1;
         end
         // any other lead byte is dropped; keep waiting for a lead byte
      end else begin
         result.wr_cont1 = (pos == u2d_pkg::POS_CONT1);
         if (pos == state.last) begin
            state_next.pos = u2d_pkg::POS_LEAD;
            result.emit    = 1'b1;
            // final byte comes straight from the input, earlier ones from storage
            unique case (state.last)
               u2d_pkg::LAST_TWO:
                  result.code = {5'b0, lead_byte[4:0], data_byte[5:0]};
               u2d_pkg::LAST_THREE:
                  result.code = {lead_byte[3:0], cont1_byte[5:0], data_byte[5:0]};
               u2d_pkg::LAST_FOUR:
                  result.code = u2d_pkg::SPACE_CODE;
               default:
                  result.code = {8'h00, data_byte};
            endcase
         end else begin
            state_next.pos = pos + 2'd1;
         end
      end
   end

endmodule

// ===== rtl/core/utf8_to_ucs2_decoder_core.sv =====
// UTF-8 to UCS-2 decoder core: one byte per beat in, zero or one code unit out.
// Pipeline: input register, then result register. Throughput: one byte per cycle unless output
// backpressure stalls the input; the single-pass step logic closes the state loop each cycle.
// Reset (synchronous, active high) clears both valid flags and the sequence position;
// stored sequence bytes are not reset. Depends on u2d_pkg and u2d_step.
module utf8_to_ucs2_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_start_of_text,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_code_unit
);

   logic                   in_valid_ff;
   logic [7:0]             in_byte_ff;
   logic                   in_sot_ff;
   u2d_pkg::seq_state_type state_ff, state_in;
   logic [7:0]             lead_ff;
   logic [7:0]             cont1_ff;
   logic                   out_valid_ff, out_valid_in;
   logic [15:0]            out_code_ff;
   u2d_pkg::step_out_type  step;
   logic                   advance;
   logic                   fire;

   // result register can take a new beat when empty or being drained
   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   u2d_step u_step (
      .data_byte     (in_byte_ff),
      .start_of_text (in_sot_ff),
      .state         (state_ff),
      .lead_byte     (lead_ff),
      .cont1_byte    (cont1_ff),
      .state_next    (state_in),
      .result        (step)
   );

   assign out_valid_in = advance ? (in_valid_ff && step.emit) : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         out_valid_ff <= out_valid_in;
         if (fire) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_data_byte;
         in_sot_ff  <= req_start_of_text;
      end
      if (fire && step.wr_lead) begin
         lead_ff <= in_byte_ff;
      end
      if (fire && step.wr_cont1) begin
         cont1_ff <= in_byte_ff;
      end
      if (fire && step.emit) begin
         out_code_ff <= step.code;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_code_unit = out_code_ff;

endmodule

// ===== rtl/core/u2d_checker.sv =====
// Port-level checks for utf8_to_ucs2_decoder_core, attached by bind.
// Depends only on the top level's ports.
module u2d_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_data_byte,
   input logic        req_start_of_text,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_code_unit
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_code_unit))
      else $error("result beat changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // input backpressure only comes from a full, stalled result register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");

   // an ASCII byte at start of text comes out unchanged through the input and result registers
   a_ascii_pass: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_start_of_text && !req_data_byte[7])
      ##1 (!rsp_valid || !rsp_stall)
      |=> rsp_valid && (rsp_code_unit == {8'h00, $past(req_data_byte, 2)}))
      else $error("ASCII byte not passed through");

endmodule

bind utf8_to_ucs2_decoder_core u2d_checker u_u2d_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_data_byte     (req_data_byte),
   .req_start_of_text (req_start_of_text),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_code_unit     (rsp_code_unit)
);
